// ----- design/mmabba_pkg.sv -----
// Package for the AB/BA matrix multiply block.
// Holds sizes, field widths, opcode, status and register codes.
// No dependencies.
package mmabba_pkg;

  localparam int MAX_DIM   = 16;
  localparam int ELEM_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int EFF_W  = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int SUM_W  = 37;
  localparam int EXT_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_BA_OFF = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_SECOND_EN = 2'd3
  } reg_idx_t;

  localparam logic PROD_AB = 1'b0;

endpackage

// ----- design/mmabba_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mmabba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/matrix_multiply_ab_ba_top.sv -----
// Top level of the AB/BA matrix multiply block: APB register file, load path,
// query sequencer and one shared multiply-accumulate unit.
// Depends on mmabba_pkg and mmabba_ram.
//
//  channel   ports                                   handshake
//  ------    -----                                   ---------
//  input     in_op in_which in_row in_col in_element start & !busy
//  result    out_product_id out_row out_col          out_valid, one cycle
//            out_sum out_status
//  config    psel penable pwrite paddr pwdata prdata  psel & penable, pready = 1
//
// A load request writes its store on the accepting clock edge; busy stays low.
// A query request holds busy through n store reads, n = inner_dim for AB or rows_a for
// BA, then through the drain and done states, with one store read and one
// multiply-accumulate per cycle through the registered RAM read, the product register and the accumulator.
// A query with nonzero status, or n = 0, goes straight to the done state with no store read.
// The strobe comes in the first cycle with busy low; the receiver cannot stall.
// Reset is synchronous; the stores are not cleared.
module matrix_multiply_ab_ba_top
  import mmabba_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_op,
  input  logic                    in_which,
  input  logic [3:0]              in_row,
  input  logic [3:0]              in_col,
  input  logic signed [15:0]      in_element,
  output logic                    out_valid,
  output logic                    out_product_id,
  output logic [3:0]              out_row,
  output logic [3:0]              out_col,
  output logic signed [SUM_W-1:0] out_sum,
  output logic [1:0]              out_status,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_t;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic [4:0] rows_a_r;
  logic [4:0] inner_dim_r;
  logic [4:0] cols_b_r;
  logic       second_en_r;

  state_t                    state_r;
  logic [IDX_W-1:0]          k_r;
  logic [EFF_W-1:0]          n_r;
  logic                      which_r;
  logic [3:0]                row_r;
  logic [3:0]                col_r;
  logic [1:0]                status_r;
  logic                      rd_v_r;
  logic                      mul_v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   acc_r;
  logic signed [SUM_W-1:0]   acc_nxt;

  logic                      out_valid_r;
  logic                      out_pid_r;
  logic [3:0]                out_row_r;
  logic [3:0]                out_col_r;
  logic signed [SUM_W-1:0]   out_sum_r;
  logic [1:0]                out_status_r;

  logic                      accept;
  logic                      cfg_wr;
  logic [EFF_W-1:0]          ra;
  logic [EFF_W-1:0]          nd;
  logic [EFF_W-1:0]          cb;
  logic                      ba_ok;
  logic [1:0]                q_status;
  logic [EFF_W-1:0]          q_n;
  logic                      in_store;
  logic signed [31:0]        elem_ext;
  logic [ELEM_BITS-1:0]      wr_elem;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ADDR_W-1:0]         left_addr;
  logic [ADDR_W-1:0]         right_addr;
  logic [ADDR_W-1:0]         a_raddr;
  logic [ADDR_W-1:0]         b_raddr;
  logic                      a_we;
  logic                      b_we;
  logic [ELEM_BITS-1:0]      a_q;
  logic [ELEM_BITS-1:0]      b_q;
  logic signed [EXT_W-1:0]   acc_ext;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= 5'd1;
      inner_dim_r <= 5'd1;
      cols_b_r    <= 5'd1;
      second_en_r <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_ROWS_A:    rows_a_r    <= pwdata[4:0];
        REG_INNER_DIM: inner_dim_r <= pwdata[4:0];
        REG_COLS_B:    cols_b_r    <= pwdata[4:0];
        REG_SECOND_EN: second_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_ROWS_A:    prdata = {27'd0, rows_a_r};
      REG_INNER_DIM: prdata = {27'd0, inner_dim_r};
      REG_COLS_B:    prdata = {27'd0, cols_b_r};
      REG_SECOND_EN: prdata = {31'd0, second_en_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign ra = (32'(rows_a_r)    > MAX_DIM) ? EFF_W'(MAX_DIM) : EFF_W'(rows_a_r);
  assign nd = (32'(inner_dim_r) > MAX_DIM) ? EFF_W'(MAX_DIM) : EFF_W'(inner_dim_r);
  assign cb = (32'(cols_b_r)    > MAX_DIM) ? EFF_W'(MAX_DIM) : EFF_W'(cols_b_r);
  assign ba_ok = second_en_r && (rows_a_r == inner_dim_r) && (inner_dim_r == cols_b_r);

  always_comb begin
    if (in_which == PROD_AB) begin
      q_n      = nd;
      q_status = ((32'(in_row) >= 32'(ra)) || (32'(in_col) >= 32'(cb))) ? ST_RANGE : ST_OK;
    end else begin
      q_n = ra;
      if (!ba_ok) begin
        q_status = ST_BA_OFF;
      end else if ((32'(in_row) >= 32'(nd)) || (32'(in_col) >= 32'(ra))) begin
        q_status = ST_RANGE;
      end else begin
        q_status = ST_OK;
      end
    end
  end

  assign in_store = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign elem_ext = 32'(in_element);
  assign wr_elem  = elem_ext[ELEM_BITS-1:0];
  assign wr_addr  = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_DIM)) + ADDR_W'(in_col);
  assign a_we     = accept && (op_t'(in_op) == OP_LOAD_A) && in_store;
  assign b_we     = accept && (op_t'(in_op) == OP_LOAD_B) && in_store;

  assign left_addr  = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(MAX_DIM)) + ADDR_W'(k_r);
  assign right_addr = ADDR_W'(ADDR_W'(k_r) * ADDR_W'(MAX_DIM)) + ADDR_W'(col_r);
  assign a_raddr    = (which_r == PROD_AB) ? left_addr : right_addr;
  assign b_raddr    = (which_r == PROD_AB) ? right_addr : left_addr;

  mmabba_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  mmabba_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  assign acc_ext = EXT_W'(acc_r) + EXT_W'(prod_r);

  always_comb begin
    if (acc_ext > EXT_W'(SUM_MAX)) begin
      acc_nxt = SUM_MAX;
    end else if (acc_ext < EXT_W'(SUM_MIN)) begin
      acc_nxt = SUM_MIN;
    end else begin
      acc_nxt = acc_ext[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_r <= $signed(a_q) * $signed(b_q);
    end
    if (accept && (op_t'(in_op) == OP_QUERY)) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      mul_v_r     <= rd_v_r;
      rd_v_r      <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && (op_t'(in_op) == OP_QUERY)) begin
            which_r  <= in_which;
            row_r    <= in_row;
            col_r    <= in_col;
            status_r <= q_status;
            n_r      <= q_n;
            k_r      <= '0;
            if ((q_status != ST_OK) || (q_n == '0)) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          rd_v_r <= 1'b1;
          k_r    <= k_r + 1'b1;
          if (EFF_W'(k_r) == n_r - EFF_W'(1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v_r && !mul_v_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r  <= 1'b1;
          out_pid_r    <= which_r;
          out_row_r    <= row_r;
          out_col_r    <= col_r;
          out_status_r <= status_r;
          out_sum_r    <= (status_r == ST_OK) ? acc_r : '0;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_product_id = out_pid_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_sum        = out_sum_r;
  assign out_status     = out_status_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer busy");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (32'(k_r) < 32'(n_r)))
    else $error("read index beyond dot product length");

  a_mul_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    mul_v_r |-> $past(rd_v_r))
    else $error("product valid without store read");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_sum_r == '0))
    else $error("nonzero sum on failed request");

  a_bad_query_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op_t'(in_op) == OP_QUERY) && (q_status != ST_OK)) |=> (state_r == S_DONE))
    else $error("failed request entered MAC sequence");

endmodule

// ----- tb/sv/tb_matrix_multiply_ab_ba_top.sv -----
// Self-checking testbench for matrix_multiply_ab_ba_top: loads A/B elements, queries AB/BA
// entries, predicts every dot product and status, and compares each strobed answer.
// Depends on mmabba_pkg and the block's RTL.
module tb_matrix_multiply_ab_ba_top
  import mmabba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_PHASES = 12;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic PROD_BA = !PROD_AB;
  localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));

  typedef struct {
    logic                    pid;
    logic [3:0]              row;
    logic [3:0]              col;
    logic signed [SUM_W-1:0] sum;
    status_t                 status;
  } mm_result_t;

  class mm_scoreboard;
    logic signed [ELEM_BITS-1:0] a_mem [DEPTH];
    logic signed [ELEM_BITS-1:0] b_mem [DEPTH];
    logic [4:0] rows_a;
    logic [4:0] inner_dim;
    logic [4:0] cols_b;
    logic       second_en;
    mm_result_t expected_q[$];
    int         errors;

    function new();
      rows_a = 5'd1;
      inner_dim = 5'd1;
      cols_b = 5'd1;
      second_en = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_ROWS_A:    rows_a = val[4:0];
        REG_INNER_DIM: inner_dim = val[4:0];
        REG_COLS_B:    cols_b = val[4:0];
        REG_SECOND_EN: second_en = val[0];
        default: ;
      endcase
    endfunction

    function int eff_size(logic [4:0] v);
      return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function status_t query_status(logic which, logic [3:0] row, logic [3:0] col);
      if (which == PROD_AB) begin
        if (row >= eff_size(rows_a) || col >= eff_size(cols_b)) return ST_RANGE;
        return ST_OK;
      end
      if (!second_en || rows_a != inner_dim || inner_dim != cols_b) return ST_BA_OFF;
      if (row >= eff_size(inner_dim) || col >= eff_size(rows_a)) return ST_RANGE;
      return ST_OK;
    endfunction

    function int query_len(logic which);
      return (which == PROD_AB) ? eff_size(inner_dim) : eff_size(rows_a);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [1:0] op, logic which, logic [3:0] row,
                               logic [3:0] col, logic signed [15:0] element);
      mm_result_t r;
      longint acc;
      int k;
      int n;
      case (op)
        OP_LOAD_A: a_mem[{row, col}] = element;
        OP_LOAD_B: b_mem[{row, col}] = element;
        OP_QUERY: begin
          r.pid = which;
          r.row = row;
          r.col = col;
          r.status = query_status(which, row, col);
          acc = 0;
          if (r.status == ST_OK) begin
            n = query_len(which);
            for (k = 0; k < n; k++) begin
              if (which == PROD_AB)
                acc += longint'(a_mem[{row, 4'(k)}]) * longint'(b_mem[{4'(k), col}]);
              else
                acc += longint'(b_mem[{row, 4'(k)}]) * longint'(a_mem[{4'(k), col}]);
              if (acc > SUM_HI) acc = SUM_HI;
              if (acc < SUM_LO) acc = SUM_LO;
            end
          end
          r.sum = acc[SUM_W-1:0];
          expected_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(mm_result_t got);
      mm_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result id=%0d row=%0d col=%0d sum=%0d status=%0d",
                   $realtime, got.pid, got.row, got.col, got.sum, got.status);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.pid !== exp_r.pid || got.row !== exp_r.row || got.col !== exp_r.col ||
          got.sum !== exp_r.sum || got.status !== exp_r.status) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"%0t: mismatch exp id=%0d row=%0d col=%0d sum=%0d status=%0d,",
                    " got id=%0d row=%0d col=%0d sum=%0d status=%0d"},
                   $realtime, exp_r.pid, exp_r.row, exp_r.col, exp_r.sum, exp_r.status,
                   got.pid, got.row, got.col, got.sum, got.status);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_op = OP_LOAD_A;
  logic                    in_which = 1'b0;
  logic [3:0]              in_row = '0;
  logic [3:0]              in_col = '0;
  logic signed [15:0]      in_element = '0;
  logic                    out_valid;
  logic                    out_product_id;
  logic [3:0]              out_row;
  logic [3:0]              out_col;
  logic signed [SUM_W-1:0] out_sum;
  logic [1:0]              out_status;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [3:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  mm_scoreboard sb = new();
  mm_result_t   seen;
  bit           a_loaded [DEPTH];
  bit           b_loaded [DEPTH];
  int           idle_pct = 0;
  int           idle_cycles = 0;

  matrix_multiply_ab_ba_top uut (.*);

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        seen.pid = out_product_id;
        seen.row = out_row;
        seen.col = out_col;
        seen.sum = out_sum;
        seen.status = status_t'(out_status);
        sb.check_result(seen);
      end
      if (start && !busy) sb.note_request(in_op, in_which, in_row, in_col, in_element);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function int pick_gap();
    int g;
    g = 0;
    while (g < 12 && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  function logic signed [15:0] rand_element();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function logic [3:0] pick_index(int dim);
    if (dim > 0 && $urandom_range(99) < 85) return 4'($urandom_range(dim - 1, 0));
    return 4'($urandom);
  endfunction

  function int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(16, 1);
    if (r < 93) return $urandom_range(31, 17);
    return 0;
  endfunction

  task automatic put_request(logic [1:0] op, logic which, logic [3:0] row, logic [3:0] col,
                             logic signed [15:0] elem);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_which <= which;
    in_row <= row;
    in_col <= col;
    in_element <= elem;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_elem(op_t op, logic [3:0] row, logic [3:0] col,
                           logic signed [15:0] elem);
    put_request(op, 1'($urandom), row, col, elem);
    if (op == OP_LOAD_A) a_loaded[{row, col}] = 1'b1;
    else b_loaded[{row, col}] = 1'b1;
  endtask

  task automatic query(logic which, logic [3:0] row, logic [3:0] col);
    int n;
    int k;
    logic [3:0] kk;
    if (sb.query_status(which, row, col) == ST_OK) begin
      n = sb.query_len(which);
      for (k = 0; k < n; k++) begin
        kk = 4'(k);
        if (which == PROD_AB) begin
          if (!a_loaded[{row, kk}]) load_elem(OP_LOAD_A, row, kk, rand_element());
          if (!b_loaded[{kk, col}]) load_elem(OP_LOAD_B, kk, col, rand_element());
        end else begin
          if (!b_loaded[{row, kk}]) load_elem(OP_LOAD_B, row, kk, rand_element());
          if (!a_loaded[{kk, col}]) load_elem(OP_LOAD_A, kk, col, rand_element());
        end
      end
    end
    put_request(OP_QUERY, which, row, col, 16'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int ra, int nd, int cb, logic se);
    write_reg(REG_ROWS_A, 32'(ra));
    write_reg(REG_INNER_DIM, 32'(nd));
    write_reg(REG_COLS_B, 32'(cb));
    write_reg(REG_SECOND_EN, 32'(se));
  endtask

  task automatic random_config();
    int n;
    logic se;
    se = ($urandom_range(99) < 80);
    if ($urandom_range(99) < 45) begin
      n = ($urandom_range(99) < 15) ? $urandom_range(31, 17) : $urandom_range(16, 1);
      set_config(n, n, n, se);
    end else begin
      set_config(pick_size(), pick_size(), pick_size(), se);
    end
  endtask

  task automatic random_item();
    int r;
    logic which;
    int d_row;
    int d_col;
    r = $urandom_range(99);
    if (r < 40) begin
      load_elem(($urandom_range(1) != 0) ? OP_LOAD_B : OP_LOAD_A, 4'($urandom), 4'($urandom),
                rand_element());
    end else if (r < 95) begin
      which = 1'($urandom);
      if (which == PROD_AB) begin
        d_row = sb.eff_size(sb.rows_a);
        d_col = sb.eff_size(sb.cols_b);
      end else begin
        d_row = sb.eff_size(sb.inner_dim);
        d_col = sb.eff_size(sb.rows_a);
      end
      query(which, pick_index(d_row), pick_index(d_col));
    end else begin
      put_request(OP_UNUSED, 1'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int ph;
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_elem(OP_LOAD_A, 4'd0, 4'd0, 16'sh7FFF);
    load_elem(OP_LOAD_B, 4'd0, 4'd0, 16'sh8000);
    query(PROD_AB, 4'd0, 4'd0);
    query(PROD_BA, 4'd0, 4'd0);
    query(PROD_AB, 4'd0, 4'd1);
    query(PROD_AB, 4'd15, 4'd15);
    query(PROD_BA, 4'd15, 4'd15);
    put_request(OP_UNUSED, 1'b1, 4'd15, 4'd15, 16'sh7FFF);
    drain();

    set_config(2, 2, 2, 1'b0);
    load_elem(OP_LOAD_A, 4'd1, 4'd1, 16'sh8000);
    load_elem(OP_LOAD_B, 4'd1, 4'd1, 16'sh8000);
    query(PROD_BA, 4'd0, 4'd0);
    query(PROD_AB, 4'd1, 4'd1);
    drain();

    set_config(0, 0, 0, 1'b1);
    query(PROD_AB, 4'd0, 4'd0);
    query(PROD_BA, 4'd0, 4'd0);
    drain();

    set_config(31, 1, 31, 1'b1);
    query(PROD_AB, 4'd15, 4'd15);
    query(PROD_BA, 4'd0, 4'd0);
    drain();

    set_config(2, 0, 3, 1'b1);
    query(PROD_AB, 4'd1, 4'd2);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 50;
        2: idle_pct = 21;
        default: idle_pct = 0;
      endcase
      if (ph == 0) set_config(16, 16, 16, 1'b1);
      else if (ph == 1) set_config(1, 1, 1, 1'b0);
      else random_config();
      for (i = 0; i < PHASE_ITEMS; i++) random_item();
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
